@@ rtl/ethhp_pkg.sv @@
// shared types, constants and codes for the ethernet/ipv4/l4 header parser
`default_nettype none

package ethhp_pkg;

  // byte position within the packet, saturating
  localparam int unsigned OFF_W = 7;
  localparam logic [OFF_W-1:0] OFFSET_MAX = 7'd127;

  // header byte positions
  localparam logic [OFF_W-1:0] OFF_SRC_MAC  = 7'd6;
  localparam logic [OFF_W-1:0] OFF_ETYPE    = 7'd12;
  localparam logic [OFF_W-1:0] ETH_HDR_LEN  = 7'd14;
  localparam logic [OFF_W-1:0] OFF_ETYPE_LO = 7'd13;
  localparam logic [OFF_W-1:0] OFF_IHL      = 7'd14;
  localparam logic [OFF_W-1:0] OFF_PROTO    = 7'd23;
  localparam logic [OFF_W-1:0] OFF_SRC_IP   = 7'd26;
  localparam logic [OFF_W-1:0] OFF_DST_IP   = 7'd30;

  // captured l4 header bytes
  localparam int unsigned L4_MAX = 20;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IHL_MIN      = 4'd5;
  localparam logic [7:0] L4_LEN_SHORT = 8'd8;
  localparam logic [7:0] L4_LEN_TCP   = 8'd20;
  localparam logic [7:0] L4_LEN_NONE  = 8'd0;

  // l3_kind codes
  localparam logic [1:0] L3_OTHER = 2'd0;
  localparam logic [1:0] L3_IPV4  = 2'd1;
  localparam logic [1:0] L3_ARP   = 2'd2;
  localparam logic [1:0] L3_TRUNC = 2'd3;

  // l4_kind codes
  localparam logic [2:0] L4_NONE = 3'd0;
  localparam logic [2:0] L4_ICMP = 3'd1;
  localparam logic [2:0] L4_IGMP = 3'd2;
  localparam logic [2:0] L4_TCP  = 3'd3;
  localparam logic [2:0] L4_UDP  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  l3_kind;
    logic [2:0]  l4_kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic        ip_options_present;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [31:0] seq_or_length;
    logic [31:0] ack_number;
    logic [57:0] tcp_detail;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/eth_ipv4_l4_header_parser_top.sv @@
// top level of the ethernet/ipv4/l4 header parser
// usage:
// - packet bytes arrive on the in_ channel, one byte per transaction, ethernet header
//   first, with last_byte set on the final byte of each packet
// - one result transaction leaves on the out_ channel for every packet, carrying mac
//   addresses, l3/l4 kinds, ip addresses and the icmp, tcp or udp header fields
// - a byte is taken every cycle while in_stall is low; the byte register, the header
//   capture and the result register each move one transaction per clock unless
//   out_stall holds them; out_valid rises when a packet's last byte moves from the
//   byte register into the result register, unless an earlier result is still held
// - while a result waits under out_stall the byte register cannot drain, so in_stall
//   rises as soon as it holds a byte; bytes move again once the result is taken
// - a packet that ends early reports l3_kind truncated with missing fields at zero
// - synchronous reset clears both valid flags and all capture state; the block is
//   ready for the first byte in the cycle after rst_n goes high
`default_nettype none

module eth_ipv4_l4_header_parser_top
  import ethhp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_stall,
  output logic          out_valid,
  output out_item_t     out_item,
  input  wire logic     out_stall
);

  logic      step_en;
  in_item_t  step_item;
  logic      can_load;
  out_item_t result;

  // byte register; it drains whenever the result register can take a transaction
  ethhp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .sink_ready (can_load),
    .step_en    (step_en),
    .step_item  (step_item)
  );

  // capture registers plus the combinational result for a last byte
  ethhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_item (step_item),
    .result    (result)
  );

  // result register, loaded only on a packet's last byte
  ethhp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en & step_item.last_byte),
    .load_item (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

@@ rtl/ethhp_in_stage.sv @@
// input register stage holding one byte transaction
`default_nettype none

module ethhp_in_stage
  import ethhp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_stall,
  input  wire logic     sink_ready,
  output logic          step_en,
  output in_item_t      step_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign step_en  = valid_r & sink_ready;
  assign in_stall = valid_r & ~sink_ready;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign step_item = item_r;

endmodule

`default_nettype wire

@@ rtl/ethhp_parser.sv @@
// header capture state and result assembly, one byte per step
`default_nettype none

module ethhp_parser
  import ethhp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t step_item,
  output out_item_t     result
);

  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic [3:0]       ihw_r, ihw_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [47:0]      dst_mac_r, dst_mac_nxt;
  logic [47:0]      src_mac_r, src_mac_nxt;
  logic [31:0]      src_ip_r, src_ip_nxt;
  logic [31:0]      dst_ip_r, dst_ip_nxt;
  logic [7:0]       l4_r   [L4_MAX];
  logic [7:0]       l4_nxt [L4_MAX];

  logic [7:0]       b;
  logic [OFF_W-1:0] off;
  logic             ip_step;
  logic [7:0]       l4_start;
  logic [7:0]       rel;
  logic             l4_wr;

  logic [7:0]       count;
  logic             is_ip;
  logic [3:0]       ihw_eff;
  logic [7:0]       l4_len;
  logic [7:0]       need;
  logic             trunc;
  logic             proto_known;

  assign b   = step_item.data_byte;
  assign off = offset_r;

  // next state for the byte in hand
  always_comb begin
    offset_nxt  = (offset_r < OFFSET_MAX) ? offset_r + 7'd1 : offset_r;
    etype_nxt   = etype_r;
    ihw_nxt     = ihw_r;
    proto_nxt   = proto_r;
    dst_mac_nxt = dst_mac_r;
    src_mac_nxt = src_mac_r;
    src_ip_nxt  = src_ip_r;
    dst_ip_nxt  = dst_ip_r;
    l4_nxt      = l4_r;

    for (int i = 0; i < 6; i++) begin
      if (off == 7'(i)) begin
        dst_mac_nxt[8*(5-i) +: 8] = b;
      end
      if (off == OFF_SRC_MAC + 7'(i)) begin
        src_mac_nxt[8*(5-i) +: 8] = b;
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (off == OFF_ETYPE + 7'(i)) begin
        etype_nxt[8*(1-i) +: 8] = b;
      end
    end

    ip_step = (etype_nxt == ETYPE_IPV4) && (off >= ETH_HDR_LEN);

    if (ip_step && off == OFF_IHL) begin
      ihw_nxt = (b[3:0] < IHL_MIN) ? IHL_MIN : b[3:0];
    end
    if (ip_step && off == OFF_PROTO) begin
      proto_nxt = b;
    end
    for (int i = 0; i < 4; i++) begin
      if (ip_step && off == OFF_SRC_IP + 7'(i)) begin
        src_ip_nxt[8*(3-i) +: 8] = b;
      end
      if (ip_step && off == OFF_DST_IP + 7'(i)) begin
        dst_ip_nxt[8*(3-i) +: 8] = b;
      end
    end

    // l4 header starts after the ip header with its options
    l4_start = {1'b0, ETH_HDR_LEN} + {2'b00, ihw_nxt, 2'b00};
    rel      = {1'b0, off} - l4_start;
    l4_wr    = ip_step && ({1'b0, off} >= l4_start) && (rel < 8'(L4_MAX));
    for (int i = 0; i < L4_MAX; i++) begin
      if (l4_wr && rel == 8'(i)) begin
        l4_nxt[i] = b;
      end
    end
  end

  // result for a last byte, taken from the updated state
  always_comb begin
    count   = {1'b0, off} + 8'd1;
    is_ip   = (etype_nxt == ETYPE_IPV4) && (off >= OFF_ETYPE_LO);
    ihw_eff = (ihw_nxt < IHL_MIN) ? IHL_MIN : ihw_nxt;
    case (proto_nxt)
      PROTO_ICMP: l4_len = L4_LEN_SHORT;
      PROTO_UDP:  l4_len = L4_LEN_SHORT;
      PROTO_TCP:  l4_len = L4_LEN_TCP;
      default:    l4_len = L4_LEN_NONE;
    endcase
    need  = {1'b0, ETH_HDR_LEN} + {2'b00, ihw_eff, 2'b00} + l4_len;
    trunc = (off < OFF_ETYPE_LO) || (is_ip && count < need);
    proto_known = is_ip && (off >= OFF_PROTO);

    result = '0;
    if (trunc) begin
      result.l3_kind = L3_TRUNC;
    end else if (etype_nxt == ETYPE_IPV4) begin
      result.l3_kind = L3_IPV4;
    end else if (etype_nxt == ETYPE_ARP) begin
      result.l3_kind = L3_ARP;
    end else begin
      result.l3_kind = L3_OTHER;
    end
    result.dst_mac            = dst_mac_nxt;
    result.src_mac            = src_mac_nxt;
    result.src_ip             = is_ip ? src_ip_nxt : 32'd0;
    result.dst_ip             = is_ip ? dst_ip_nxt : 32'd0;
    result.ip_options_present = is_ip && (ihw_nxt > IHL_MIN);

    if (proto_known) begin
      case (proto_nxt)
        PROTO_ICMP: begin
          result.l4_kind    = L4_ICMP;
          result.first_word = {l4_nxt[0], l4_nxt[1]};
        end
        PROTO_IGMP: begin
          result.l4_kind = L4_IGMP;
        end
        PROTO_TCP: begin
          result.l4_kind       = L4_TCP;
          result.first_word    = {l4_nxt[0], l4_nxt[1]};
          result.second_word   = {l4_nxt[2], l4_nxt[3]};
          result.seq_or_length = {l4_nxt[4], l4_nxt[5], l4_nxt[6], l4_nxt[7]};
          result.ack_number    = {l4_nxt[8], l4_nxt[9], l4_nxt[10], l4_nxt[11]};
          result.tcp_detail    = {l4_nxt[12][7:4], l4_nxt[13][5:0],
                                  l4_nxt[14], l4_nxt[15], l4_nxt[16],
                                  l4_nxt[17], l4_nxt[18], l4_nxt[19]};
        end
        PROTO_UDP: begin
          result.l4_kind       = L4_UDP;
          result.first_word    = {l4_nxt[0], l4_nxt[1]};
          result.second_word   = {l4_nxt[2], l4_nxt[3]};
          result.seq_or_length = {16'd0, l4_nxt[4], l4_nxt[5]};
        end
        default: begin
          result.l4_kind = L4_NONE;
        end
      endcase
    end
  end

  // state clears on reset and after the last byte of every packet
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step_item.last_byte)) begin
      offset_r  <= '0;
      etype_r   <= '0;
      ihw_r     <= '0;
      proto_r   <= '0;
      dst_mac_r <= '0;
      src_mac_r <= '0;
      src_ip_r  <= '0;
      dst_ip_r  <= '0;
      for (int i = 0; i < L4_MAX; i++) begin
        l4_r[i] <= '0;
      end
    end else if (step_en) begin
      offset_r  <= offset_nxt;
      etype_r   <= etype_nxt;
      ihw_r     <= ihw_nxt;
      proto_r   <= proto_nxt;
      dst_mac_r <= dst_mac_nxt;
      src_mac_r <= src_mac_nxt;
      src_ip_r  <= src_ip_nxt;
      dst_ip_r  <= dst_ip_nxt;
      l4_r      <= l4_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ethhp_out_stage.sv @@
// result register with valid/stall towards the receiver
`default_nettype none

module ethhp_out_stage
  import ethhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t load_item,
  output logic           can_load,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      out_stall
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

@@ rtl/ethhp_checker.sv @@
// port level checks for the header parser, bound to the top level
`default_nettype none

module ethhp_checker
  import ethhp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire in_item_t  in_item,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire out_item_t out_item,
  input wire logic      out_stall
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled byte transaction holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled byte changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // results of kind other or arp carry no l4 kind and no ip addresses
  a_non_ip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.l3_kind == L3_OTHER || out_item.l3_kind == L3_ARP) |->
      out_item.l4_kind == L4_NONE && out_item.src_ip == 32'd0 &&
      out_item.dst_ip == 32'd0)
    else $error("non-ipv4 result carries ip fields");

  // tcp-only fields stay zero for other protocols
  a_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.l4_kind != L4_TCP |->
      out_item.ack_number == 32'd0 && out_item.tcp_detail == 58'd0)
    else $error("tcp fields set on a non-tcp result");

endmodule

bind eth_ipv4_l4_header_parser_top ethhp_checker u_ethhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_item   (in_item),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_item  (out_item),
  .out_stall (out_stall)
);

`default_nettype wire

@@ tb/eth_ipv4_l4_header_parser_top_tb.sv @@
// self-checking testbench for the ethernet/ipv4/l4 header parser top level
module eth_ipv4_l4_header_parser_top_tb;
  import ethhp_pkg::*;

  // ipv4 header length without options, in bytes
  localparam int IP_BASE_LEN = 20;
  // ethertype high byte; ethertype, version/ihl and protocol sit at fixed offsets in every generated packet
  localparam int OFF_ETYPE_HI = 12;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  // one queued byte; hold keeps the sender back until every header result is home
  typedef struct {
    in_item_t item;
    bit       hold;
  } stream_entry_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;

  stream_entry_t byte_stream[$];    // bytes waiting for the driver
  out_item_t     parsed_headers[$]; // predicted results, oldest first

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          in_took = 1'b0;      // byte accepted at the last rising edge

  // predictor state: mirrors the capture registers of the parser
  int unsigned byte_pos;
  logic [15:0] eth_type;
  logic [3:0]  ihl_words;
  logic [7:0]  ip_proto;
  logic [47:0] dmac;
  logic [47:0] smac;
  logic [31:0] sip;
  logic [31:0] dip;
  logic [7:0]  l4_hdr[L4_MAX];

  always #10 clk = ~clk;

  eth_ipv4_l4_header_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // ---------------------------------------------------------------------------
  // header predictor
  // ---------------------------------------------------------------------------

  function automatic int l4_hdr_len(input logic [7:0] proto);
    if (proto == PROTO_ICMP || proto == PROTO_UDP) return int'(L4_LEN_SHORT);
    if (proto == PROTO_TCP) return int'(L4_LEN_TCP);
    return int'(L4_LEN_NONE);
  endfunction

  // big-endian 16-bit word from the captured l4 header
  function automatic logic [15:0] hdr_word(input int i);
    return {l4_hdr[i], l4_hdr[i+1]};
  endfunction

  task automatic clear_parser();
    byte_pos = 0;
    eth_type = '0;
    ihl_words = '0;
    ip_proto = '0;
    dmac = '0;
    smac = '0;
    sip = '0;
    dip = '0;
    foreach (l4_hdr[i]) l4_hdr[i] = '0;
  endtask

  // advance the predictor by one accepted byte; a last byte yields one header result
  task automatic parse_byte(input in_item_t it);
    int        off;
    int        cnt;
    int        l4_start;
    int        needed;
    bit        ip_pkt;
    out_item_t res;
    off = byte_pos;
    // ethernet header: capture registers start at zero so plain writes are enough
    if (off < OFF_SRC_MAC) dmac[8*(5-off) +: 8] = it.data_byte;
    else if (off < OFF_ETYPE) smac[8*(11-off) +: 8] = it.data_byte;
    else if (off < ETH_HDR_LEN) eth_type[8*(13-off) +: 8] = it.data_byte;
    ip_pkt = (eth_type == ETYPE_IPV4) && off >= ETH_HDR_LEN;
    if (ip_pkt) begin
      if (off == OFF_IHL) begin
        // ihl below five counts as five
        ihl_words = (it.data_byte[3:0] < IHL_MIN) ? IHL_MIN : it.data_byte[3:0];
      end else if (off == OFF_PROTO) begin
        ip_proto = it.data_byte;
      end else if (off >= OFF_SRC_IP && off < OFF_DST_IP) begin
        sip[8*(int'(OFF_DST_IP)-1-off) +: 8] = it.data_byte;
      end else if (off >= OFF_DST_IP && off < int'(OFF_DST_IP) + 4) begin
        dip[8*(int'(OFF_DST_IP)+3-off) +: 8] = it.data_byte;
      end
      l4_start = int'(ETH_HDR_LEN) + 4 * int'(ihl_words);
      if (off >= l4_start && off - l4_start < L4_MAX) l4_hdr[off-l4_start] = it.data_byte;
    end
    if (byte_pos < OFFSET_MAX) byte_pos++;

    if (it.last_byte) begin
      cnt = off + 1;
      ip_pkt = (eth_type == ETYPE_IPV4) && cnt >= ETH_HDR_LEN;
      l4_start = int'(ETH_HDR_LEN) + 4 * int'(ihl_words);
      needed = int'(ETH_HDR_LEN);
      if (ip_pkt) needed = l4_start + l4_hdr_len(ip_proto);
      if (ip_pkt && cnt < int'(ETH_HDR_LEN) + IP_BASE_LEN)
        needed = int'(ETH_HDR_LEN) + IP_BASE_LEN;
      res = '0;
      if (cnt < needed || cnt < ETH_HDR_LEN) res.l3_kind = L3_TRUNC;
      else if (eth_type == ETYPE_IPV4) res.l3_kind = L3_IPV4;
      else if (eth_type == ETYPE_ARP) res.l3_kind = L3_ARP;
      else res.l3_kind = L3_OTHER;
      // the protocol is reported once its byte has arrived, even when truncated
      if (ip_pkt && cnt > OFF_PROTO) begin
        case (ip_proto)
          PROTO_ICMP: begin
            res.l4_kind = L4_ICMP;
            res.first_word = hdr_word(0);
          end
          PROTO_IGMP: begin
            res.l4_kind = L4_IGMP;
          end
          PROTO_TCP: begin
            res.l4_kind = L4_TCP;
            res.first_word = hdr_word(0);
            res.second_word = hdr_word(2);
            res.seq_or_length = {hdr_word(4), hdr_word(6)};
            res.ack_number = {hdr_word(8), hdr_word(10)};
            res.tcp_detail = {l4_hdr[12][7:4], l4_hdr[13][5:0],
                              hdr_word(14), hdr_word(16), hdr_word(18)};
          end
          PROTO_UDP: begin
            res.l4_kind = L4_UDP;
            res.first_word = hdr_word(0);
            res.second_word = hdr_word(2);
            res.seq_or_length = {16'h0000, hdr_word(4)};
          end
          default: res.l4_kind = L4_NONE;
        endcase
      end
      res.dst_mac = dmac;
      res.src_mac = smac;
      if (ip_pkt) begin
        res.src_ip = sip;
        res.dst_ip = dip;
        res.ip_options_present = ihl_words > IHL_MIN;
      end
      parsed_headers.push_back(res);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_header(input out_item_t got);
    out_item_t want;
    if (parsed_headers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result transaction with no packet outstanding: %h", got);
    end else begin
      want = parsed_headers.pop_front();
      check_field("l3_kind", 64'(want.l3_kind), 64'(got.l3_kind));
      check_field("l4_kind", 64'(want.l4_kind), 64'(got.l4_kind));
      check_field("dst_mac", 64'(want.dst_mac), 64'(got.dst_mac));
      check_field("src_mac", 64'(want.src_mac), 64'(got.src_mac));
      check_field("src_ip", 64'(want.src_ip), 64'(got.src_ip));
      check_field("dst_ip", 64'(want.dst_ip), 64'(got.dst_ip));
      check_field("ip_options_present", 64'(want.ip_options_present),
                  64'(got.ip_options_present));
      check_field("first_word", 64'(want.first_word), 64'(got.first_word));
      check_field("second_word", 64'(want.second_word), 64'(got.second_word));
      check_field("seq_or_length", 64'(want.seq_or_length), 64'(got.seq_or_length));
      check_field("ack_number", 64'(want.ack_number), 64'(got.ack_number));
      check_field("tcp_detail", 64'(want.tcp_detail), 64'(got.tcp_detail));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver and monitor
  // ---------------------------------------------------------------------------

  // inputs move on the falling edge; a stalled byte stays put until it is taken
  always @(negedge clk) begin : drive_bytes
    stream_entry_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      // a held byte waits until the block has handed back every header
      if (byte_stream.size() != 0 && !(byte_stream[0].hold && parsed_headers.size() != 0)
          && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_stream.pop_front();
        in_item <= nxt.item;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // both channels are sampled on the rising edge, before the block updates
  always @(posedge clk) begin : watch_channels
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        bytes_taken++;
        parse_byte(in_item);
      end
      if (out_valid && !out_stall) check_header(out_item);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // queue one packet; ethertype, version/ihl and protocol overwrite the fill
  task automatic queue_packet(input logic [15:0] etype, input logic [7:0] vihl,
                              input logic [7:0] proto, input int len,
                              input fill_t fill, input bit hold);
    stream_entry_t e;
    logic [7:0]    b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hff;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom);
      endcase
      if (i == OFF_ETYPE_HI) b = etype[15:8];
      else if (i == OFF_ETYPE_LO) b = etype[7:0];
      else if (i == OFF_IHL) b = vihl;
      else if (i == OFF_PROTO) b = proto;
      e.item.data_byte = b;
      e.item.last_byte = (i == len - 1);
      e.hold = hold && (i == 0);
      byte_stream.push_back(e);
      bytes_queued++;
    end
  endtask

  // mostly well-formed headers with random content, plus truncated and odd packets
  task automatic queue_random_packet();
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    int          full;
    int          len;
    int          r;
    r = $urandom_range(99);
    if (r < 75) etype = ETYPE_IPV4;
    else if (r < 85) etype = ETYPE_ARP;
    else etype = 16'($urandom);
    r = $urandom_range(99);
    if (r < 25) proto = PROTO_TCP;
    else if (r < 45) proto = PROTO_UDP;
    else if (r < 65) proto = PROTO_ICMP;
    else if (r < 75) proto = PROTO_IGMP;
    else proto = 8'($urandom);
    r = $urandom_range(99);
    if (r < 70) ihl = IHL_MIN;
    else if (r < 85) ihl = 4'($urandom_range(6, 15));
    else ihl = 4'($urandom_range(0, 4));
    if (etype == ETYPE_IPV4)
      full = int'(ETH_HDR_LEN) + 4 * ((ihl < IHL_MIN) ? int'(IHL_MIN) : int'(ihl))
             + l4_hdr_len(proto);
    else if (etype == ETYPE_ARP)
      full = int'(ETH_HDR_LEN) + 28;
    else
      full = int'(ETH_HDR_LEN) + $urandom_range(0, 20);
    r = $urandom_range(99);
    if (r < 65) len = full + $urandom_range(0, 8);
    else if (r < 85) len = $urandom_range(1, full - 1);
    else if (r < 95) len = full + $urandom_range(9, 40);
    else len = $urandom_range(120, 150);   // around and past the offset saturation
    queue_packet(etype, {4'($urandom), ihl}, proto, len, FILL_RANDOM,
                 $urandom_range(19) == 0);
  endtask

  // short directed set: field extremes, every protocol and the corner cases
  task automatic queue_directed_packets();
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 1, FILL_ONES, 1'b0);      // single byte
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 13, FILL_ONES, 1'b0);     // short ethernet
    queue_packet(16'hffff, 8'hff, 8'hff, 14, FILL_ONES, 1'b0);           // other ethertype
    queue_packet(ETYPE_IPV4, 8'h00, 8'h00, 14, FILL_ZEROS, 1'b0);        // ipv4, no ip header
    queue_packet(ETYPE_ARP, 8'h00, 8'h00, 42, FILL_ZEROS, 1'b0);         // arp
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_ICMP, 42, FILL_RANDOM, 1'b0);  // icmp
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_IGMP, 40, FILL_RANDOM, 1'b0);  // igmp
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 54, FILL_ONES, 1'b0);     // tcp, all ones
    queue_packet(ETYPE_IPV4, 8'h4f, PROTO_UDP, 82, FILL_RANDOM, 1'b1);   // widest options
    queue_packet(ETYPE_IPV4, 8'h40, PROTO_TCP, 54, FILL_RANDOM, 1'b0);   // ihl zero
    queue_packet(ETYPE_IPV4, 8'h46, 8'hff, 40, FILL_RANDOM, 1'b0);       // unknown protocol
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 23, FILL_RANDOM, 1'b0);   // protocol missing
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 24, FILL_RANDOM, 1'b0);   // protocol only
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_TCP, 45, FILL_RANDOM, 1'b0);   // tcp cut short
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_UDP, 140, FILL_RANDOM, 1'b0);  // long packet
    queue_packet(ETYPE_IPV4, 8'h45, PROTO_UDP, 42, FILL_ONES, 1'b0);     // udp, all ones
  endtask

  // wait until every queued byte is taken and every header has come back
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || parsed_headers.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned phase_pkts;
    clear_parser();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // three idling phases: receiver-heavy stalls, sender-heavy gaps, then flat out
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) queue_directed_packets();
      phase_start = bytes_queued;
      phase_pkts = 0;
      while (bytes_queued - phase_start < 270 || phase_pkts < 4) begin
        queue_random_packet();
        phase_pkts++;
      end
      wait_drained();
    end

    // give a stray result time to show up
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ethhp_pkg.sv
rtl/ethhp_in_stage.sv
rtl/ethhp_parser.sv
rtl/ethhp_out_stage.sv
rtl/eth_ipv4_l4_header_parser_top.sv
rtl/ethhp_checker.sv
tb/eth_ipv4_l4_header_parser_top_tb.sv
